// ===== sv/pcsof_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsof_pkg
// Types and widths shared by the point cloud sigma outlier filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsof_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned MULT_W     = 4;
  localparam int unsigned MULT_RESET = 2;

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW  = COORD_W + AW;
  localparam int unsigned DW  = SW + 1;
  localparam int unsigned AAW = DW + AW;
  localparam int unsigned HW  = (AAW + 1) / 2;
  localparam int unsigned QW  = 2 * AAW;
  localparam int unsigned TW  = QW + AW;
  localparam int unsigned K2W = 2 * MULT_W;
  localparam int unsigned RW  = TW + K2W;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [TAG_W-1:0]          point_tag;
    logic                      set_end;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [TAG_W-1:0]          out_tag;
    logic                      kept;
    logic                      run_last;
    logic                      overflowed;
  } out_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] coord;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== sv/point_cloud_sigma_outlier_filter.sv =====
// ----------------------------------------------------------------------------
// point_cloud_sigma_outlier_filter
// Per-axis statistical outlier removal over sets of up to MAX_POINTS points.
// ----------------------------------------------------------------------------
// Points load at one transaction per cycle into a single point RAM while the
// per-axis sums accumulate. The transaction with set_end starts filtering: the
// block then refuses input and makes three walks over the RAM, one read per
// point, with all three axes handled in parallel: mean distance, squared
// deviation sum (paced by the two-step squaring multiplier), then judgment and
// output, which waits while the output stalls. Points beyond capacity are
// dropped and flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module point_cloud_sigma_outlier_filter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire pcsof_pkg::in_t                      in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output pcsof_pkg::out_t                          out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pcsof_pkg::MULT_W-1:0]        cfg_data_i
);

  localparam int unsigned AW  = pcsof_pkg::AW;
  localparam int unsigned CW  = pcsof_pkg::CW;
  localparam int unsigned SW  = pcsof_pkg::SW;
  localparam int unsigned DW  = pcsof_pkg::DW;
  localparam int unsigned AAW = pcsof_pkg::AAW;
  localparam int unsigned HW  = pcsof_pkg::HW;
  localparam int unsigned QW  = pcsof_pkg::QW;
  localparam int unsigned TW  = pcsof_pkg::TW;
  localparam int unsigned K2W = pcsof_pkg::K2W;
  localparam int unsigned RW  = pcsof_pkg::RW;
  localparam int unsigned CDW = pcsof_pkg::COORD_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MEAN,
    ST_DEV,
    ST_RHS,
    ST_JUDGE
  } state_e;

  localparam logic [2:0] PH_MEAN  = 3'd2;
  localparam logic [2:0] PH_DEV   = 3'd5;
  localparam logic [2:0] PH_JUDGE = 3'd6;

  state_e                            state_q;
  logic [2:0]                        ph_q;
  logic [AW-1:0]                     idx_q;
  logic [CW-1:0]                     cnt_q;
  logic [2:0][SW-1:0]                sum_q;
  logic                              ovf_q;
  logic [pcsof_pkg::MULT_W-1:0]      k_q;
  logic                              out_valid_q;
  pcsof_pkg::out_t                   out_q;

  logic [2:0][AAW-1:0]               a_q;
  logic [2:0][TW-1:0]                t_q;
  logic [2:0][RW-1:0]                rhs_q;
  logic [2:0][DW-1:0]                d_q;
  logic [2:0][AAW-1:0]               m_q;
  logic [2:0]                        neg_q;
  logic [2:0][AAW+HW-1:0]            pp_q;
  logic [2:0][QW-1:0]                sq_q;
  logic [2:0][TW-1:0]                lhs_q;

  logic                              in_acc;
  logic                              room;
  logic                              last_pt;
  logic                              out_free;
  logic                              emit;
  logic                              wr_en;
  pcsof_pkg::entry_t                 wr_entry;
  pcsof_pkg::entry_t                 rd_entry;
  logic [2:0][DW-1:0]                d_d;
  logic [2:0][AAW-1:0]               m_d;
  logic [2:0]                        neg_d;
  logic [2:0]                        pass;
  logic [K2W-1:0]                    k2;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign room        = (cnt_q < CW'(pcsof_pkg::MAX_POINTS));
  assign wr_en       = in_acc && room;
  assign last_pt     = (idx_q == AW'(cnt_q - CW'(1)));
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == ST_JUDGE) && (ph_q == PH_JUDGE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign k2          = K2W'(k_q * k_q);

  assign wr_entry.coord[0] = in_data_i.coord_x;
  assign wr_entry.coord[1] = in_data_i.coord_y;
  assign wr_entry.coord[2] = in_data_i.coord_z;
  assign wr_entry.tag      = in_data_i.point_tag;

  pcsof_ram #(
    .WIDTH(pcsof_pkg::ENTRY_W),
    .DEPTH(pcsof_pkg::MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(wr_entry),
    .raddr_i(idx_q),
    .rdata_o(rd_entry)
  );

  always_comb begin
    logic signed [CDW+CW:0] nv;
    logic signed [DW:0]     diff;
    logic [AAW-1:0]         nd;
    logic signed [AAW:0]    e;
    for (int a = 0; a < 3; a++) begin
      nv       = $signed({1'b0, cnt_q}) * $signed(rd_entry.coord[a]);
      diff     = (DW+1)'(nv) - (DW+1)'($signed(sum_q[a]));
      d_d[a]   = diff[DW] ? DW'(-diff) : DW'(diff);
      nd       = AAW'(cnt_q * d_q[a]);
      e        = $signed({1'b0, nd}) - $signed({1'b0, a_q[a]});
      neg_d[a] = e[AAW];
      m_d[a]   = e[AAW] ? AAW'(-e) : AAW'(e);
      pass[a]  = neg_q[a] || (RW'(lhs_q[a]) < rhs_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      d_q[a]   <= d_d[a];
      m_q[a]   <= m_d[a];
      neg_q[a] <= neg_d[a];
      pp_q[a]  <= m_q[a] * m_q[a][HW-1:0];
      sq_q[a]  <= QW'(pp_q[a]) + (QW'(m_q[a] * m_q[a][AAW-1:HW]) << HW);
      lhs_q[a] <= TW'(sq_q[a] * AW'(cnt_q - CW'(1)));
    end
    if (in_acc && in_data_i.set_end) begin
      a_q <= '0;
      t_q <= '0;
    end
    for (int a = 0; a < 3; a++) begin
      if (state_q == ST_MEAN && ph_q == PH_MEAN) begin
        a_q[a] <= a_q[a] + AAW'(d_q[a]);
      end
      if (state_q == ST_DEV && ph_q == PH_DEV) begin
        t_q[a] <= t_q[a] + TW'(sq_q[a]);
      end
      if (state_q == ST_RHS) begin
        rhs_q[a] <= RW'(t_q[a] * k2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      ph_q        <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      k_q         <= pcsof_pkg::MULT_W'(pcsof_pkg::MULT_RESET);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        k_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt_q    <= cnt_q + CW'(1);
              sum_q[0] <= sum_q[0] + SW'(in_data_i.coord_x);
              sum_q[1] <= sum_q[1] + SW'(in_data_i.coord_y);
              sum_q[2] <= sum_q[2] + SW'(in_data_i.coord_z);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.set_end) begin
              state_q <= ST_MEAN;
              idx_q   <= '0;
              ph_q    <= '0;
            end
          end
        end
        ST_MEAN, ST_DEV: begin
          if ((state_q == ST_MEAN && ph_q == PH_MEAN) ||
              (state_q == ST_DEV && ph_q == PH_DEV)) begin
            ph_q <= '0;
            if (last_pt) begin
              idx_q   <= '0;
              state_q <= (state_q == ST_MEAN) ? ST_DEV : ST_RHS;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_RHS: begin
          state_q <= ST_JUDGE;
          ph_q    <= '0;
        end
        ST_JUDGE: begin
          if (ph_q != PH_JUDGE) begin
            ph_q <= ph_q + 3'd1;
          end else if (out_free) begin
            out_q.out_x        <= rd_entry.coord[0];
            out_q.out_y        <= rd_entry.coord[1];
            out_q.out_z        <= rd_entry.coord[2];
            out_q.out_tag      <= rd_entry.tag;
            out_q.kept         <= &pass;
            out_q.run_last     <= last_pt;
            out_q.overflowed   <= ovf_q;
            ph_q               <= '0;
            if (last_pt) begin
              idx_q   <= '0;
              cnt_q   <= '0;
              sum_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcsof_ram.sv =====
// ----------------------------------------------------------------------------
// pcsof_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsof_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sim/point_cloud_sigma_outlier_filter_tb.sv =====
// ----------------------------------------------------------------------------
// point_cloud_sigma_outlier_filter_tb
// Drives point sets through the outlier filter and checks every emitted point.
// Each set is judged on arrival of set_end by an exact integer predictor; the
// results are compared field by field in order. Sender bursts and gaps, receiver
// stalls, multiplier changes between sets and an over-capacity set are covered.
// ----------------------------------------------------------------------------
`default_nettype none

module point_cloud_sigma_outlier_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned MAX_POINTS  = pcsof_pkg::MAX_POINTS;
  localparam int unsigned COORD_W     = pcsof_pkg::COORD_W;
  localparam int unsigned TAG_W       = pcsof_pkg::TAG_W;
  localparam int unsigned MULT_W      = pcsof_pkg::MULT_W;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  pcsof_pkg::in_t      in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pcsof_pkg::out_t     out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [MULT_W-1:0]   cfg_data_i = '0;

  point_cloud_sigma_outlier_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  pcsof_pkg::in_t   points_pending[$];
  pcsof_pkg::out_t  points_expected[$];

  longint            set_coord[MAX_POINTS][3];
  logic [TAG_W-1:0]  set_tag[MAX_POINTS];
  longint            set_sum[3];
  int unsigned       set_count;
  bit                set_overflow;
  logic [MULT_W-1:0] multiplier = MULT_W'(pcsof_pkg::MULT_RESET);
  bit                point_ok[MAX_POINTS];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned sets_judged = 0;
  int unsigned points_seen = 0;
  int unsigned points_kept = 0;
  int unsigned overflow_sets = 0;
  bit          in_taken = 1'b0;
  bit          cfg_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  function automatic void add_pending(input pcsof_pkg::in_t p);
    points_pending.insert(points_pending.size(), p);
  endfunction

  function automatic void judge_axis(input int ax);
    logic signed [127:0] n, s, k2, dsum, sq, e, d;
    n = 128'(set_count);
    s = 128'(set_sum[ax]);
    k2 = multiplier * multiplier;
    dsum = 0;
    sq = 0;
    for (int i = 0; i < set_count; i++) begin
      d = n * set_coord[i][ax] - s;
      dsum += (d < 0) ? -d : d;
    end
    for (int i = 0; i < set_count; i++) begin
      d = n * set_coord[i][ax] - s;
      e = n * ((d < 0) ? -d : d) - dsum;
      sq += e * e;
    end
    for (int i = 0; i < set_count; i++) begin
      d = n * set_coord[i][ax] - s;
      e = n * ((d < 0) ? -d : d) - dsum;
      if (e >= 0 && e * e * (n - 1) >= k2 * sq) point_ok[i] = 1'b0;
    end
  endfunction

  function automatic void take_point(input pcsof_pkg::in_t p);
    pcsof_pkg::out_t r;
    if (set_count < MAX_POINTS) begin
      set_coord[set_count][0] = longint'(p.coord_x);
      set_coord[set_count][1] = longint'(p.coord_y);
      set_coord[set_count][2] = longint'(p.coord_z);
      set_tag[set_count] = p.point_tag;
      for (int a = 0; a < 3; a++) set_sum[a] += set_coord[set_count][a];
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!p.set_end) return;
    for (int i = 0; i < set_count; i++) point_ok[i] = 1'b1;
    for (int a = 0; a < 3; a++) judge_axis(a);
    for (int i = 0; i < set_count; i++) begin
      r.out_x = COORD_W'(set_coord[i][0]);
      r.out_y = COORD_W'(set_coord[i][1]);
      r.out_z = COORD_W'(set_coord[i][2]);
      r.out_tag = set_tag[i];
      r.kept = point_ok[i];
      r.run_last = (i + 1 == set_count);
      r.overflowed = set_overflow;
      points_expected.insert(points_expected.size(), r);
    end
    sets_judged++;
    if (set_overflow) overflow_sets++;
    set_count = 0;
    set_overflow = 1'b0;
    for (int a = 0; a < 3; a++) set_sum[a] = 0;
  endfunction

  always @(posedge clk_i) begin
    pcsof_pkg::out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        multiplier = cfg_data_i;
        cfg_taken = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        take_point(in_data_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (points_expected.size() == 0) begin
          $error("unexpected result tag %0h", out_data_o.out_tag);
          errors++;
        end else begin
          want = points_expected.pop_front();
          points_seen++;
          if (out_data_o.kept) points_kept++;
          if (out_data_o.out_x !== want.out_x) begin
            $error("out_x exp %0d got %0d", want.out_x, out_data_o.out_x); errors++;
          end
          if (out_data_o.out_y !== want.out_y) begin
            $error("out_y exp %0d got %0d", want.out_y, out_data_o.out_y); errors++;
          end
          if (out_data_o.out_z !== want.out_z) begin
            $error("out_z exp %0d got %0d", want.out_z, out_data_o.out_z); errors++;
          end
          if (out_data_o.out_tag !== want.out_tag) begin
            $error("out_tag exp %0h got %0h", want.out_tag, out_data_o.out_tag); errors++;
          end
          if (out_data_o.kept !== want.kept) begin
            $error("kept exp %0b got %0b", want.kept, out_data_o.kept); errors++;
          end
          if (out_data_o.run_last !== want.run_last) begin
            $error("run_last exp %0b got %0b", want.run_last, out_data_o.run_last);
            errors++;
          end
          if (out_data_o.overflowed !== want.overflowed) begin
            $error("overflowed exp %0b got %0b", want.overflowed, out_data_o.overflowed);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0 || points_pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_data_i <= points_pending.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 1) != 0);
      default: out_ready_i <= (cycles % 7 < 2);
    endcase
  end

  function automatic pcsof_pkg::in_t make_point(input longint x, input longint y,
                                                input longint z, input bit last);
    pcsof_pkg::in_t p;
    p.coord_x = COORD_W'(x);
    p.coord_y = COORD_W'(y);
    p.coord_z = COORD_W'(z);
    p.point_tag = TAG_W'($urandom_range(0, 16'hffff));
    p.set_end = last;
    return p;
  endfunction

  function automatic longint near(input longint c, input int unsigned spread);
    longint v;
    v = c + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  task automatic queue_random_set(input int unsigned n, input bit wide);
    longint cx, cy, cz;
    pcsof_pkg::in_t p;
    int unsigned spread;
    cx = longint'($urandom_range(0, 24'hffffff)) - 8388608;
    cy = longint'($urandom_range(0, 24'hffffff)) - 8388608;
    cz = longint'($urandom_range(0, 24'hffffff)) - 8388608;
    spread = $urandom_range(1, 5000);
    for (int i = 0; i < n; i++) begin
      if (wide || $urandom_range(0, 9) == 0) begin
        p.coord_x = COORD_W'($urandom);
        p.coord_y = COORD_W'($urandom);
        p.coord_z = COORD_W'($urandom);
        p.point_tag = TAG_W'($urandom);
        p.set_end = (i == n - 1);
      end else begin
        p = make_point(near(cx, spread), near(cy, spread), near(cz, spread), i == n - 1);
      end
      add_pending(p);
    end
  endtask

  task automatic wait_idle();
    while (points_pending.size() != 0 || in_valid_i || points_expected.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_multiplier(input logic [MULT_W-1:0] k);
    @(negedge clk_i);
    cfg_data_i <= k;
    cfg_valid_i <= 1'b1;
    cfg_taken = 1'b0;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_pending(make_point(8388607, 8388607, 8388607, 1'b1));
    add_pending(make_point(-8388608, -8388608, -8388608, 1'b1));
    add_pending(make_point(-8388608, 8388607, 0, 1'b0));
    add_pending(make_point(8388607, -8388608, 0, 1'b1));
    for (int i = 0; i < 3; i++) add_pending(make_point(100, -5, 77, i == 2));
    for (int i = 0; i < 5; i++)
      add_pending(make_point(i, 2 * i, -i, 1'b0));
    add_pending(make_point(8000000, 3, -3, 1'b1));
    wait_idle();

    write_multiplier(MULT_W'(0));
    queue_random_set(6, 1'b0);
    wait_idle();
    write_multiplier(MULT_W'(15));
    queue_random_set(6, 1'b0);
    queue_random_set(2, 1'b1);
    wait_idle();
    write_multiplier(MULT_W'(1));

    for (int i = 0; i < 66; i++)
      add_pending(make_point(near(0, 2000), near(0, 2000), near(0, 2000), i == 65));
    wait_idle();

    for (int s = 0; s < 2; s++) begin
      if (s == 1) begin
        wait_idle();
        write_multiplier(MULT_W'($urandom_range(0, 15)));
      end
      queue_random_set($urandom_range(2, 10), $urandom_range(0, 4) == 0);
    end
    wait_idle();
    write_multiplier(MULT_W'(pcsof_pkg::MULT_RESET));
    queue_random_set(8, 1'b0);

    while (points_pending.size() != 0 || in_valid_i || points_expected.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("Judged %0d point sets (%0d over capacity), multipliers 0 to 15.",
             sets_judged, overflow_sets);
    $display("Checked %0d emitted points, %0d of them kept.", points_seen, points_kept);
    if (errors == 0 && points_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
